// ===== hdl/drrip_pkg.sv =====
// shared constants, types and helpers for the dueling rrip replacement block
// no dependencies
`default_nettype none

package drrip_pkg;

  localparam int SetIdxW   = 10;
  localparam int WayFieldW = 4;
  localparam int RateW     = 4;
  localparam int LfsrW     = 16;

  localparam logic [RateW-1:0] RateReset = 4'd6;
  localparam logic [LfsrW-1:0] LfsrSeed  = 16'hACE1;
  localparam logic [LfsrW-1:0] LfsrTaps  = 16'hB400;

  typedef enum logic [1:0] {
    KIND_FOLLOW,
    KIND_SRRIP,
    KIND_BRRIP
  } leader_e;

  function automatic int floor_log2(input int v);
    int n;
    int x;
    n = 0;
    x = v;
    while (x > 1) begin
      x = x >> 1;
      n++;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/drrip_victim.sv =====
// victim selection and aging for one set row of rrpv values
// standalone, no package needed
`default_nettype none

module drrip_victim #(
  parameter int WAYS      = 16,
  parameter int RRPV_BITS = 2
) (
  input  wire logic [WAYS*RRPV_BITS-1:0] row_i,
  output logic      [WAYS*RRPV_BITS-1:0] aged_row_o,
  output logic      [$clog2(WAYS)-1:0]   victim_o
);

  localparam int NumVals = 1 << RRPV_BITS;
  localparam int WayIdxW = $clog2(WAYS);
  localparam logic [RRPV_BITS-1:0] Dist = {RRPV_BITS{1'b1}};

  logic [NumVals-1:0]   present;
  logic [RRPV_BITS-1:0] top;
  logic [RRPV_BITS-1:0] add;
  logic                 found;

  always_comb begin
    present = '0;
    for (int w = 0; w < WAYS; w++) begin
      present[row_i[w*RRPV_BITS +: RRPV_BITS]] = 1'b1;
    end
    top = '0;
    for (int v = 0; v < NumVals; v++) begin
      if (present[v]) begin
        top = RRPV_BITS'(v);
      end
    end
    add = Dist - top;
    for (int w = 0; w < WAYS; w++) begin
      aged_row_o[w*RRPV_BITS +: RRPV_BITS] = row_i[w*RRPV_BITS +: RRPV_BITS] + add;
    end
    found    = 1'b0;
    victim_o = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!found && row_i[w*RRPV_BITS +: RRPV_BITS] == top) begin
        victim_o = WayIdxW'(w);
        found    = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/dueling_rrip_replacement.sv =====
// top level of the dueling rrip replacement block: row memory, policy counter, lfsr
// depends on drrip_pkg and drrip_victim
`default_nettype none

// Usage:
//   An item (func, set_index, way, hit) is taken at a clock edge with start
//   high and busy low. func 0 asks for a victim, func 1 is a hit or fill
//   update. A victim item yields one result: victim_valid_o is high for one
//   cycle with victim_way_o, registered in ST_RUN after the set row has
//   been read into rdata_q. Updates yield no result.
//   Each item reads the set row from the row memory, then modifies it and
//   writes it back. busy is high in ST_RUN, during the write back, so a new
//   item is not taken before the last one is written back.
//   The receiver cannot stall; a result is valid in exactly one cycle and
//   the next item may be taken in that same cycle.
//   After reset the row memory is cleared to the distant value, one row per
//   cycle, with busy high until the last row is written. cfg_we_i/cfg_data_i
//   write the bimodal rate register at any time, including during the clear.
module dueling_rrip_replacement #(
  parameter int NUM_SETS       = 1024,
  parameter int WAYS           = 16,
  parameter int RRPV_BITS      = 2,
  parameter int DUEL_BITS      = 10,
  parameter int LEADER_REGIONS = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            func_i,
  input  wire logic [drrip_pkg::SetIdxW-1:0]   set_index_i,
  input  wire logic [drrip_pkg::WayFieldW-1:0] way_i,
  input  wire logic                            hit_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [drrip_pkg::RateW-1:0]     cfg_data_i,
  output logic                                 victim_valid_o,
  output logic      [drrip_pkg::WayFieldW-1:0] victim_way_o
);

  import drrip_pkg::*;

  localparam int SetW    = $clog2(NUM_SETS);
  localparam int RowW    = WAYS * RRPV_BITS;
  localparam int WayIdxW = $clog2(WAYS);
  localparam int SBits   = floor_log2(NUM_SETS);
  localparam int LBits   = floor_log2(LEADER_REGIONS);
  localparam int OffBits = (SBits > LBits) ? (SBits - LBits) : 0;

  localparam logic [RRPV_BITS-1:0] Dist    = {RRPV_BITS{1'b1}};
  localparam logic [RRPV_BITS-1:0] Long    = Dist - 1'b1;
  localparam logic [DUEL_BITS-1:0] PselMax = {DUEL_BITS{1'b1}};
  localparam logic [SetW-1:0]      OffMask = SetW'((64'd1 << OffBits) - 64'd1);
  localparam logic [SetW-1:0]      LastSet = SetW'(NUM_SETS - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CLEAR = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [SetW-1:0]      clr_q, clr_d;
  logic [RateW-1:0]     rate_q;
  logic [DUEL_BITS-1:0] psel_q, psel_d;
  logic [LfsrW-1:0]     lfsr_q, lfsr_d;
  logic                 func_q, hit_q;
  logic [SetW-1:0]      set_q;
  logic [WayFieldW-1:0] way_q;
  logic                 valid_q;
  logic [WayFieldW-1:0] victim_q;

  logic [RowW-1:0] mem [NUM_SETS];
  logic [RowW-1:0] rdata_q;

  logic            accept;
  logic [SetW-1:0] set_idx;
  logic            way_ok;
  logic            run;
  leader_e         kind;
  logic            use_bim;
  logic [LfsrW-1:0] lfsr_nxt;
  logic [LfsrW-1:0] rate_mask;
  logic            bim_long;
  logic [RRPV_BITS-1:0] old_slot, new_slot;
  logic [RowW-1:0] upd_row, aged_row, wdata;
  logic [WayIdxW-1:0] victim;
  logic            we;
  logic [SetW-1:0] waddr;
  logic [SetW-1:0] region, offset, offset_n;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign run    = (state_q == ST_RUN);

  generate
    if (SetW <= SetIdxW) begin : g_set_narrow
      assign set_idx = set_index_i[SetW-1:0];
    end else begin : g_set_wide
      assign set_idx = SetW'(set_index_i);
    end
  endgenerate

  drrip_victim #(
    .WAYS      (WAYS),
    .RRPV_BITS (RRPV_BITS)
  ) u_victim (
    .row_i      (rdata_q),
    .aged_row_o (aged_row),
    .victim_o   (victim)
  );

  // leader set classification
  always_comb begin
    region   = set_q >> OffBits;
    offset   = set_q & OffMask;
    offset_n = ~set_q & OffMask;
    priority if (region == offset) begin
      kind = KIND_SRRIP;
    end else if (region == offset_n) begin
      kind = KIND_BRRIP;
    end else begin
      kind = KIND_FOLLOW;
    end
  end

  always_comb begin
    unique case (kind)
      KIND_SRRIP: use_bim = 1'b0;
      KIND_BRRIP: use_bim = 1'b1;
      default:    use_bim = psel_q[DUEL_BITS-1];
    endcase
  end

  assign way_ok    = (int'(way_q) < WAYS);
  assign lfsr_nxt  = (lfsr_q >> 1) ^ (lfsr_q[0] ? LfsrTaps : '0);
  assign rate_mask = LfsrW'((17'd1 << rate_q) - 17'd1);
  assign bim_long  = ((lfsr_nxt & rate_mask) == '0);

  // update path for one way of the row
  always_comb begin
    old_slot = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (int'(way_q) == w) begin
        old_slot = rdata_q[w*RRPV_BITS +: RRPV_BITS];
      end
    end
    if (hit_q) begin
      new_slot = (old_slot != '0) ? old_slot - 1'b1 : '0;
    end else if (use_bim) begin
      new_slot = bim_long ? Long : Dist;
    end else begin
      new_slot = Long;
    end
    upd_row = rdata_q;
    for (int w = 0; w < WAYS; w++) begin
      if (int'(way_q) == w) begin
        upd_row[w*RRPV_BITS +: RRPV_BITS] = new_slot;
      end
    end
  end

  always_comb begin
    lfsr_d = lfsr_q;
    psel_d = psel_q;
    if (run && func_q && way_ok && !hit_q) begin
      if (use_bim) begin
        lfsr_d = lfsr_nxt;
      end
      if (kind == KIND_SRRIP && psel_q != PselMax) begin
        psel_d = psel_q + 1'b1;
      end else if (kind == KIND_BRRIP && psel_q != '0) begin
        psel_d = psel_q - 1'b1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == LastSet) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (state_q == ST_CLEAR) begin
      we    = 1'b1;
      waddr = clr_q;
      wdata = {WAYS{Dist}};
    end else begin
      we    = run && (!func_q || way_ok);
      waddr = set_q;
      wdata = func_q ? upd_row : aged_row;
    end
  end

  // row memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (accept) begin
      rdata_q <= mem[set_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      rate_q  <= RateReset;
      psel_q  <= '0;
      lfsr_q  <= LfsrSeed;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      psel_q  <= psel_d;
      lfsr_q  <= lfsr_d;
      valid_q <= run && !func_q;
      if (cfg_we_i) begin
        rate_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      set_q  <= set_idx;
      way_q  <= way_i;
      hit_q  <= hit_i;
    end
    if (run) begin
      victim_q <= WayFieldW'(victim);
    end
  end

  assign victim_valid_o = valid_q;
  assign victim_way_o   = victim_q;

  a_strobe_after_victim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    victim_valid_o |-> $past(state_q == ST_RUN && !func_q))
    else $error("result strobe without a victim item");

  a_clear_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(state_q == ST_CLEAR) && state_q == ST_IDLE) |-> $past(clr_q == LastSet))
    else $error("clearing pass ended early");

  a_psel_only_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(psel_q) |-> $past(run && func_q && !hit_q))
    else $error("policy counter moved outside a miss update");

  a_lfsr_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lfsr_q != '0)
    else $error("lfsr reached the all-zero state");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |=> (state_q != ST_RUN))
    else $error("item taken during clearing pass");

endmodule

`default_nettype wire
